### design/sfr_pkg.sv
// shared types and constants for the sbus frame receiver
// no dependencies; the design files but sfr_ram use it by scoped names
`timescale 1ns / 1ps

package sfr_pkg;

  // request kinds on the input channel
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [7:0]  START_BYTE   = 8'h0F;
  localparam logic [15:0] OVERRUN_MARK = 16'hFFFE;

  localparam int unsigned GAP_W     = 16;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned TIMEOUT_W = 24;
  localparam int unsigned CFG_W     = 24;

  // frame store: two banks of 32 byte slots, address is {bank, byte index}
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned RAM_DEPTH  = 64;
  localparam int unsigned RAM_ADDR_W = 6;

  localparam logic [IDX_W-1:0] FIRST_DATA_BYTE = 5'd1;
  localparam logic [IDX_W-1:0] FLAG_BYTE       = 5'd23;
  localparam logic [IDX_W-1:0] TAIL_BYTE       = 5'd24;

  localparam int unsigned LOST_BIT     = 2;
  localparam int unsigned FAILSAFE_BIT = 3;

  // channel unpacking
  localparam int unsigned CHAN_W    = 11;
  localparam int unsigned ACC_W     = 18;
  localparam int unsigned ACC_CNT_W = 5;
  localparam logic [ACC_CNT_W-1:0] BYTE_BITS = 5'd8;
  localparam logic [ACC_CNT_W-1:0] CHAN_BITS = 5'd11;
  localparam logic [3:0]           LAST_CHANNEL = 4'd8;

  localparam int unsigned CMD_FIFO_DEPTH = 4;
  localparam int unsigned CMD_PTR_W      = 2;

  typedef enum logic [1:0] {
    CFG_GAP_LIMIT       = 2'd0,
    CFG_LOST_TIMEOUT    = 2'd1,
    CFG_NOFRAME_TIMEOUT = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    RES_CHANNEL = 2'd0,
    RES_REJECT  = 2'd1,
    RES_STATUS  = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_REJECT = 2'd1,
    CMD_FRAME  = 2'd2
  } cmd_kind_e;

  typedef enum logic {
    F_HUNT   = 1'b0,
    F_GATHER = 1'b1
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE       = 3'd0,
    B_FLAG_APPLY = 3'd1,
    B_CHAN_RD    = 3'd2,
    B_CHAN_LD    = 3'd3,
    B_CHAN_EMIT  = 3'd4
  } back_state_e;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  rx_byte;
    logic [15:0] gap_ticks;
    logic [15:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    result_kind_e result_kind;
    logic [3:0]   channel_index;
    logic [10:0]  channel_value;
    logic         last_of_run;
    logic         frame_lost_bit;
    logic         sbus_failsafe_bit;
    logic         signal_lost;
    logic         no_frames;
    logic         failsafe_out;
  } out_item_t;

  typedef struct packed {
    logic [GAP_W-1:0]     gap_limit;
    logic [TIMEOUT_W-1:0] lost_timeout_us;
    logic [TIMEOUT_W-1:0] noframe_timeout_us;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [ELAPSED_W-1:0] elapsed_us;
    logic                 bank;
  } cmd_t;

  // back to front: a frame bank has been fully unpacked
  typedef struct packed {
    logic done;
    logic bank;
  } back_status_t;

endpackage

### design/sbus_frame_receiver_top.sv
// top level of the sbus frame receiver: configuration registers and the
// front end, command queue, back end and frame store ram; uses sfr_pkg
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o  in_item_i (byte or tick)
// out       output     out_valid_o/out_stall_i out_item_o (result)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a byte or tick is taken when not stalled; a full queue or a start byte whose
// frame bank is still being unpacked holds the input stalled
// a tick or reject result is made in the back end idle state; a good frame
// holds the back end for command, flag byte, 13 byte reads, 9 channel emits
// unpacking goes on while a result waits; a stalled result blocks further emits
// after reset the block hunts for a start byte; cfg_ready_o is always high

module sbus_frame_receiver_top #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  sfr_pkg::in_item_t         in_item_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  output sfr_pkg::out_item_t        out_item_o,
  input  logic                      out_stall_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [sfr_pkg::CFG_W-1:0] cfg_data_i
);

  sfr_pkg::cfg_t         cfg_q;
  logic                  push, fifo_full, pop, cmd_valid;
  sfr_pkg::cmd_t         push_cmd, head_cmd;
  logic                  ram_we, ram_re;
  logic [sfr_pkg::RAM_ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]            ram_wdata, ram_rdata;
  sfr_pkg::back_status_t back_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_limit          <= 16'd1024;
      cfg_q.lost_timeout_us    <= 24'd1000000;
      cfg_q.noframe_timeout_us <= 24'd1000000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sfr_pkg::CFG_GAP_LIMIT:
          cfg_q.gap_limit <= cfg_data_i[sfr_pkg::GAP_W-1:0];
        sfr_pkg::CFG_LOST_TIMEOUT:
          cfg_q.lost_timeout_us <= cfg_data_i[sfr_pkg::TIMEOUT_W-1:0];
        sfr_pkg::CFG_NOFRAME_TIMEOUT:
          cfg_q.noframe_timeout_us <= cfg_data_i[sfr_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  sfr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gap_limit_i   (cfg_q.gap_limit),
    .in_valid_i    (in_valid_i),
    .in_item_i     (in_item_i),
    .in_stall_o    (in_stall_o),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .back_status_i (back_status)
  );

  sfr_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .valid_o     (cmd_valid),
    .head_o      (head_cmd)
  );

  sfr_ram #(
    .Width (8),
    .Depth (sfr_pkg::RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sfr_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .lost_timeout_us_i    (cfg_q.lost_timeout_us),
    .noframe_timeout_us_i (cfg_q.noframe_timeout_us),
    .cmd_valid_i          (cmd_valid),
    .cmd_i                (head_cmd),
    .cmd_pop_o            (pop),
    .ram_re_o             (ram_re),
    .ram_raddr_o          (ram_raddr),
    .ram_rdata_i          (ram_rdata),
    .status_o             (back_status),
    .out_valid_o          (out_valid_o),
    .out_item_o           (out_item_o),
    .out_stall_i          (out_stall_i)
  );

endmodule

### design/sfr_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sfr_cmd_fifo.sv
// short command queue between the front end and the back end
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfr_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sfr_pkg::cmd_t head_o
);

  sfr_pkg::cmd_t                  mem_q [sfr_pkg::CMD_FIFO_DEPTH];
  logic [sfr_pkg::CMD_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [sfr_pkg::CMD_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [sfr_pkg::CMD_PTR_W:0]    count_q, count_d;
  logic                           do_push, do_pop;

  assign full_o  = (count_q == (sfr_pkg::CMD_PTR_W + 1)'(sfr_pkg::CMD_FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> !do_pop)
    else $error("command queue popped while empty");
  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("command queue count lost a request");
  a_head_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !do_pop) |=> $stable(rd_ptr_q))
    else $error("command queue head moved without pop");
`endif

endmodule

### design/sfr_front.sv
// front end: takes bytes and ticks, hunts for start, gathers frames into
// the frame store banks and queues tick, reject and frame commands; uses sfr_pkg
`timescale 1ns / 1ps

module sfr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sfr_pkg::GAP_W-1:0]     gap_limit_i,
  input  logic                          in_valid_i,
  input  sfr_pkg::in_item_t             in_item_i,
  output logic                          in_stall_o,
  input  logic                          fifo_full_i,
  output logic                          push_o,
  output sfr_pkg::cmd_t                 cmd_o,
  output logic                          ram_we_o,
  output logic [sfr_pkg::RAM_ADDR_W-1:0] ram_waddr_o,
  output logic [7:0]                    ram_wdata_o,
  input  sfr_pkg::back_status_t         back_status_i
);

  sfr_pkg::front_state_e         state_q, state_d;
  logic [sfr_pkg::IDX_W-1:0]     count_q, count_d;
  logic                          late_q, late_d;
  logic                          bank_q, bank_d;
  logic [1:0]                    busy_q, busy_d;

  logic is_tick, is_start, is_last, byte_late, accept, frame_ok;

  assign is_tick   = (in_item_i.req_type == sfr_pkg::REQ_TICK);
  assign is_start  = (state_q == sfr_pkg::F_HUNT) && !is_tick &&
                     (in_item_i.rx_byte == sfr_pkg::START_BYTE);
  assign is_last   = (state_q == sfr_pkg::F_GATHER) && !is_tick &&
                     (count_q == sfr_pkg::TAIL_BYTE);
  assign byte_late = (in_item_i.gap_ticks == sfr_pkg::OVERRUN_MARK) ||
                     (in_item_i.gap_ticks > gap_limit_i);
  assign frame_ok  = !(late_q || byte_late);

  // a new frame waits until its bank has been unpacked by the back end
  assign in_stall_o = fifo_full_i || (is_start && busy_q[bank_q]);
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sfr_pkg::F_HUNT: begin
        if (accept && is_start) begin
          state_d = sfr_pkg::F_GATHER;
        end
      end
      sfr_pkg::F_GATHER: begin
        if (accept && is_last) begin
          state_d = sfr_pkg::F_HUNT;
        end
      end
      default: state_d = sfr_pkg::F_HUNT;
    endcase
  end

  // outputs and bookkeeping
  always_comb begin
    push_o         = 1'b0;
    cmd_o.kind     = sfr_pkg::CMD_TICK;
    cmd_o.elapsed_us = in_item_i.elapsed_us;
    cmd_o.bank     = bank_q;
    ram_we_o       = 1'b0;
    ram_waddr_o    = {bank_q, count_q};
    ram_wdata_o    = in_item_i.rx_byte;
    count_d        = count_q;
    late_d         = late_q;
    bank_d         = bank_q;
    busy_d         = busy_q;
    if (back_status_i.done) begin
      busy_d[back_status_i.bank] = 1'b0;
    end
    if (accept) begin
      if (is_tick) begin
        push_o = 1'b1;
      end else if (is_start) begin
        count_d = sfr_pkg::FIRST_DATA_BYTE;
        late_d  = 1'b0;
      end else if (state_q == sfr_pkg::F_GATHER) begin
        ram_we_o = 1'b1;
        late_d   = late_q || byte_late;
        count_d  = count_q + 1'b1;
        if (is_last) begin
          push_o  = 1'b1;
          count_d = '0;
          late_d  = 1'b0;
          if (frame_ok) begin
            cmd_o.kind     = sfr_pkg::CMD_FRAME;
            busy_d[bank_q] = 1'b1;
            bank_d         = !bank_q;
          end else begin
            cmd_o.kind = sfr_pkg::CMD_REJECT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfr_pkg::F_HUNT;
      count_q <= '0;
      late_q  <= 1'b0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      late_q  <= late_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

`ifndef SYNTHESIS
  a_no_busy_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !busy_q[bank_q])
    else $error("frame byte written into a bank still being unpacked");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !fifo_full_i)
    else $error("command pushed into a full queue");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status_i.done |-> busy_q[back_status_i.bank])
    else $error("back end finished a bank that was not handed over");
`endif

endmodule

### design/sfr_back.sv
// back end: runs queued commands, keeps failsafe timers and flags, unpacks
// channels from the frame store and drives the result register; uses sfr_pkg
`timescale 1ns / 1ps

module sfr_back #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [sfr_pkg::TIMEOUT_W-1:0]  lost_timeout_us_i,
  input  logic [sfr_pkg::TIMEOUT_W-1:0]  noframe_timeout_us_i,
  input  logic                           cmd_valid_i,
  input  sfr_pkg::cmd_t                  cmd_i,
  output logic                           cmd_pop_o,
  output logic                           ram_re_o,
  output logic [sfr_pkg::RAM_ADDR_W-1:0] ram_raddr_o,
  input  logic [7:0]                     ram_rdata_i,
  output sfr_pkg::back_status_t          status_o,
  output logic                           out_valid_o,
  output sfr_pkg::out_item_t             out_item_o,
  input  logic                           out_stall_i
);

  localparam int unsigned CmpW = (TIMER_WIDTH > sfr_pkg::TIMEOUT_W) ?
                                 TIMER_WIDTH : sfr_pkg::TIMEOUT_W;

  sfr_pkg::back_state_e state_q, state_d;

  logic [TIMER_WIDTH-1:0] lost_timer_q, since_timer_q;
  logic                   lost_active_q, signal_lost_q, failsafe_bit_q, no_frames_q;

  logic [sfr_pkg::ACC_W-1:0]     acc_q;
  logic [sfr_pkg::ACC_CNT_W-1:0] cnt_q;
  logic [3:0]                    ch_q;
  logic [sfr_pkg::IDX_W-1:0]     byte_idx_q;
  logic                          bank_q;

  logic                   out_valid_q;
  sfr_pkg::out_item_t     out_q, emit_item;
  logic                   emit, slot_free, tick_fire, frame_start;

  logic [TIMER_WIDTH:0]   lost_sum, since_sum;
  logic [TIMER_WIDTH-1:0] lost_sat, since_sat;
  logic                   no_frames_tick, lost_over;

  assign slot_free = !out_valid_q || !out_stall_i;

  // saturating timer advance on a tick
  assign lost_sum  = {1'b0, lost_timer_q} + (TIMER_WIDTH + 1)'(cmd_i.elapsed_us);
  assign since_sum = {1'b0, since_timer_q} + (TIMER_WIDTH + 1)'(cmd_i.elapsed_us);
  assign lost_sat  = lost_sum[TIMER_WIDTH] ? '1 : lost_sum[TIMER_WIDTH-1:0];
  assign since_sat = since_sum[TIMER_WIDTH] ? '1 : since_sum[TIMER_WIDTH-1:0];
  assign no_frames_tick = CmpW'(since_sat) > CmpW'(noframe_timeout_us_i);
  assign lost_over      = CmpW'(lost_timer_q) > CmpW'(lost_timeout_us_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sfr_pkg::B_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == sfr_pkg::CMD_FRAME)) begin
          state_d = sfr_pkg::B_FLAG_APPLY;
        end
      end
      sfr_pkg::B_FLAG_APPLY: state_d = sfr_pkg::B_CHAN_RD;
      sfr_pkg::B_CHAN_RD:    state_d = sfr_pkg::B_CHAN_LD;
      sfr_pkg::B_CHAN_LD: begin
        if ((cnt_q + sfr_pkg::BYTE_BITS) >= sfr_pkg::CHAN_BITS) begin
          state_d = sfr_pkg::B_CHAN_EMIT;
        end else begin
          state_d = sfr_pkg::B_CHAN_RD;
        end
      end
      sfr_pkg::B_CHAN_EMIT: begin
        if (slot_free) begin
          if (ch_q == sfr_pkg::LAST_CHANNEL) begin
            state_d = sfr_pkg::B_IDLE;
          end else begin
            state_d = sfr_pkg::B_CHAN_RD;
          end
        end
      end
      default: state_d = sfr_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o    = 1'b0;
    ram_re_o     = 1'b0;
    ram_raddr_o  = {bank_q, byte_idx_q};
    status_o     = '{done: 1'b0, bank: bank_q};
    emit         = 1'b0;
    tick_fire    = 1'b0;
    frame_start  = 1'b0;
    emit_item.result_kind       = sfr_pkg::RES_STATUS;
    emit_item.channel_index     = '0;
    emit_item.channel_value     = '0;
    emit_item.last_of_run       = 1'b1;
    emit_item.frame_lost_bit    = lost_active_q;
    emit_item.sbus_failsafe_bit = failsafe_bit_q;
    emit_item.signal_lost       = signal_lost_q;
    emit_item.no_frames         = no_frames_q;
    case (state_q)
      sfr_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            sfr_pkg::CMD_TICK: begin
              if (slot_free) begin
                cmd_pop_o = 1'b1;
                tick_fire = 1'b1;
                emit      = 1'b1;
                emit_item.no_frames = no_frames_tick;
              end
            end
            sfr_pkg::CMD_REJECT: begin
              if (slot_free) begin
                cmd_pop_o = 1'b1;
                emit      = 1'b1;
                emit_item.result_kind = sfr_pkg::RES_REJECT;
              end
            end
            sfr_pkg::CMD_FRAME: begin
              // flag byte comes first so every channel result sees new flags
              cmd_pop_o   = 1'b1;
              frame_start = 1'b1;
              ram_re_o    = 1'b1;
              ram_raddr_o = {cmd_i.bank, sfr_pkg::FLAG_BYTE};
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      sfr_pkg::B_CHAN_RD: ram_re_o = 1'b1;
      sfr_pkg::B_CHAN_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_item.result_kind   = sfr_pkg::RES_CHANNEL;
          emit_item.channel_index = ch_q;
          emit_item.channel_value = acc_q[sfr_pkg::CHAN_W-1:0];
          emit_item.last_of_run   = (ch_q == sfr_pkg::LAST_CHANNEL);
          status_o.done           = (ch_q == sfr_pkg::LAST_CHANNEL);
        end
      end
      default: ;
    endcase
    emit_item.failsafe_out = emit_item.signal_lost || emit_item.sbus_failsafe_bit ||
                             emit_item.no_frames;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= sfr_pkg::B_IDLE;
      out_valid_q    <= 1'b0;
      lost_timer_q   <= '0;
      since_timer_q  <= '0;
      lost_active_q  <= 1'b0;
      signal_lost_q  <= 1'b0;
      failsafe_bit_q <= 1'b0;
      no_frames_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (tick_fire) begin
        if (lost_active_q) begin
          lost_timer_q <= lost_sat;
        end
        since_timer_q <= since_sat;
        no_frames_q   <= no_frames_tick;
      end
      if (state_q == sfr_pkg::B_FLAG_APPLY) begin
        if (ram_rdata_i[sfr_pkg::LOST_BIT]) begin
          if (!lost_active_q) begin
            lost_active_q <= 1'b1;
            lost_timer_q  <= '0;
          end else if (lost_over) begin
            signal_lost_q <= 1'b1;
          end
        end else begin
          lost_active_q <= 1'b0;
          lost_timer_q  <= '0;
          signal_lost_q <= 1'b0;
        end
        failsafe_bit_q <= ram_rdata_i[sfr_pkg::FAILSAFE_BIT];
        since_timer_q  <= '0;
        no_frames_q    <= 1'b0;
      end
    end
  end

  // unpacking datapath
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_item;
    end
    if (frame_start) begin
      bank_q <= cmd_i.bank;
    end
    case (state_q)
      sfr_pkg::B_FLAG_APPLY: begin
        acc_q      <= '0;
        cnt_q      <= '0;
        ch_q       <= '0;
        byte_idx_q <= sfr_pkg::FIRST_DATA_BYTE;
      end
      sfr_pkg::B_CHAN_RD: byte_idx_q <= byte_idx_q + 1'b1;
      sfr_pkg::B_CHAN_LD: begin
        acc_q <= acc_q | (sfr_pkg::ACC_W'(ram_rdata_i) << cnt_q);
        cnt_q <= cnt_q + sfr_pkg::BYTE_BITS;
      end
      sfr_pkg::B_CHAN_EMIT: begin
        if (slot_free) begin
          acc_q <= acc_q >> sfr_pkg::CHAN_W;
          cnt_q <= cnt_q - sfr_pkg::CHAN_BITS;
          ch_q  <= ch_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free)
    else $error("result overwrote a result still waiting");
  a_frame_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_start |=> (state_q == sfr_pkg::B_FLAG_APPLY))
    else $error("frame command did not read its flag byte");
  a_enough_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sfr_pkg::B_CHAN_EMIT) |-> (cnt_q >= sfr_pkg::CHAN_BITS))
    else $error("channel emitted before eleven bits were gathered");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.done |=> (state_q == sfr_pkg::B_IDLE))
    else $error("bank released while unpacking continues");
`endif

endmodule

### bench/sbus_frame_receiver_top_tb.sv
// testbench for sbus_frame_receiver_top: drives bytes and ticks, decodes frames in a local
// model and checks every result field; random idling, a long receiver hold-off, config phases
// depends on sfr_pkg and the design files only
`timescale 1ns / 1ps

module sbus_frame_receiver_top_tb;
  import sfr_pkg::*;

  localparam int unsigned TIMER_WIDTH = 24;
  localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_WIDTH) - 64'd1;
  localparam int FRAME_BYTES = TAIL_BYTE + 1;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NO_BAD_BYTE = 0;
  localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  in_item_t in_item_i;
  logic in_stall_o;
  logic out_valid_o;
  out_item_t out_item_o;
  logic out_stall_i;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  // decoder model state
  cfg_t cfg_shadow = '{gap_limit: 16'd1024, lost_timeout_us: 24'd1000000,
                       noframe_timeout_us: 24'd1000000};
  bit gathering = 1'b0;
  int frame_pos = 0;
  logic [7:0] frame_bytes [FRAME_BYTES];
  bit late_flag = 1'b0;
  bit lost_running = 1'b0;
  longint unsigned lost_us = 0;
  bit sig_lost = 1'b0;
  bit fs_bit = 1'b0;
  longint unsigned idle_us = 0;
  bit no_frame = 1'b0;
  out_item_t decoded_q [$];

  int fail_count = 0;
  int checked_count = 0;
  int good_frames = 0;
  int rejected_frames = 0;
  int status_reports = 0;
  int sent_count = 0;
  int cycle_count = 0;
  bit steady = 1'b0;
  bit holding = 1'b0;
  event hold_start;

  sbus_frame_receiver_top #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [10:0] got,
                             input logic [10:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  function automatic longint unsigned timer_add(input longint unsigned t, input logic [15:0] d);
    longint unsigned s;
    s = t + d;
    return (s > TIMER_MAX) ? TIMER_MAX : s;
  endfunction

  function automatic void push_result(input result_kind_e kind, input logic [3:0] idx,
                                      input logic [10:0] val, input logic last);
    out_item_t r;
    r.result_kind = kind;
    r.channel_index = idx;
    r.channel_value = val;
    r.last_of_run = last;
    r.frame_lost_bit = lost_running;
    r.sbus_failsafe_bit = fs_bit;
    r.signal_lost = sig_lost;
    r.no_frames = no_frame;
    r.failsafe_out = sig_lost | fs_bit | no_frame;
    decoded_q.push_back(r);
  endfunction

  // works out the results one accepted request causes
  task automatic decode_request(input in_item_t it);
    logic [7:0] flags;
    logic [23:0] bits;
    int first;
    if (it.req_type == REQ_TICK) begin
      if (lost_running) lost_us = timer_add(lost_us, it.elapsed_us);
      idle_us = timer_add(idle_us, it.elapsed_us);
      no_frame = idle_us > cfg_shadow.noframe_timeout_us;
      push_result(RES_STATUS, 4'd0, 11'd0, 1'b1);
      status_reports++;
      return;
    end
    if (!gathering) begin
      if (it.rx_byte == START_BYTE) begin
        gathering = 1'b1;
        frame_bytes[0] = it.rx_byte;
        frame_pos = 1;
        late_flag = 1'b0;
      end
      return;
    end
    frame_bytes[frame_pos] = it.rx_byte;
    if (it.gap_ticks == OVERRUN_MARK || it.gap_ticks > cfg_shadow.gap_limit) late_flag = 1'b1;
    frame_pos++;
    if (frame_pos < FRAME_BYTES) return;
    gathering = 1'b0;
    frame_pos = 0;
    if (late_flag) begin
      late_flag = 1'b0;
      push_result(RES_REJECT, 4'd0, 11'd0, 1'b1);
      rejected_frames++;
      return;
    end
    flags = frame_bytes[FLAG_BYTE];
    if (flags[LOST_BIT]) begin
      if (!lost_running) begin
        lost_running = 1'b1;
        lost_us = 0;
      end
      if (lost_us > cfg_shadow.lost_timeout_us) sig_lost = 1'b1;
    end else begin
      lost_running = 1'b0;
      lost_us = 0;
      sig_lost = 1'b0;
    end
    fs_bit = flags[FAILSAFE_BIT];
    idle_us = 0;
    no_frame = idle_us > cfg_shadow.noframe_timeout_us;
    // channels are packed lsb first from byte 1 on
    for (int k = 0; k <= LAST_CHANNEL; k++) begin
      first = 1 + (CHAN_W * k) / 8;
      bits = {frame_bytes[first + 2], frame_bytes[first + 1], frame_bytes[first]};
      push_result(RES_CHANNEL, 4'(k), 11'(bits >> ((CHAN_W * k) % 8)), k == LAST_CHANNEL);
    end
    good_frames++;
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result arrived with nothing pending");
      end else begin
        want = decoded_q.pop_front();
        checked_count++;
        check_field("result_kind", out_item_o.result_kind, want.result_kind);
        check_field("channel_index", out_item_o.channel_index, want.channel_index);
        check_field("channel_value", out_item_o.channel_value, want.channel_value);
        check_field("last_of_run", out_item_o.last_of_run, want.last_of_run);
        check_field("frame_lost_bit", out_item_o.frame_lost_bit, want.frame_lost_bit);
        check_field("sbus_failsafe_bit", out_item_o.sbus_failsafe_bit, want.sbus_failsafe_bit);
        check_field("signal_lost", out_item_o.signal_lost, want.signal_lost);
        check_field("no_frames", out_item_o.no_frames, want.no_frames);
        check_field("failsafe_out", out_item_o.failsafe_out, want.failsafe_out);
      end
    end
  end

  // receiver long hold-off
  initial begin
    forever begin
      @(hold_start);
      holding = 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clk_i);
      holding = 1'b0;
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= holding || (!steady && $urandom_range(99) < 26);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count,
             decoded_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_item_t byte_req(input logic [7:0] b, input logic [15:0] gap);
    in_item_t it;
    it.req_type = REQ_BYTE;
    it.rx_byte = b;
    it.gap_ticks = gap;
    it.elapsed_us = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t tick_req(input logic [15:0] el);
    in_item_t it;
    it.req_type = REQ_TICK;
    it.rx_byte = 8'($urandom);
    it.gap_ticks = 16'($urandom);
    it.elapsed_us = el;
    return it;
  endfunction

  function automatic logic [15:0] legal_gap();
    logic [15:0] g;
    g = ($urandom_range(4) == 0) ? cfg_shadow.gap_limit
                                 : 16'($urandom_range(cfg_shadow.gap_limit));
    if (g == OVERRUN_MARK) g = g - 16'd1;
    return g;
  endfunction

  function automatic logic [15:0] late_gap();
    if (cfg_shadow.gap_limit >= OVERRUN_MARK || $urandom_range(1) == 0) return OVERRUN_MARK;
    return 16'($urandom_range(16'hFFFF, cfg_shadow.gap_limit + 1));
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_request(input in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    decode_request(it);
    sent_count++;
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic release_sender();
    if (in_valid_i) in_valid_i <= 1'b0;
  endtask

  task automatic send_frame(input fill_e fill, input logic [7:0] flags,
                            input logic [15:0] start_gap, input int bad_pos,
                            input logic [15:0] bad_gap, input int tick_pct);
    logic [7:0] b;
    logic [15:0] g;
    send_request(byte_req(START_BYTE, start_gap));
    for (int i = 1; i <= TAIL_BYTE; i++) begin
      if ($urandom_range(99) < tick_pct) send_request(tick_req(16'($urandom)));
      case (fill)
        FILL_ONES: b = 8'hFF;
        FILL_ZEROS: b = 8'h00;
        default: b = 8'($urandom);
      endcase
      if (i == FLAG_BYTE) b = flags;
      g = (i == bad_pos) ? bad_gap : legal_gap();
      send_request(byte_req(b, g));
    end
  endtask

  // finish any partial frame, then wait until every result is out and the block is quiet
  task automatic settle();
    while (gathering) send_request(byte_req(8'($urandom), 16'd0));
    release_sender();
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_GAP_LIMIT: cfg_shadow.gap_limit = data[GAP_W-1:0];
      CFG_LOST_TIMEOUT: cfg_shadow.lost_timeout_us = data;
      CFG_NOFRAME_TIMEOUT: cfg_shadow.noframe_timeout_us = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_hunting();
    send_request(tick_req(16'h0000));
    send_request(byte_req(8'h00, 16'h0000));
    send_request(byte_req(8'hFF, 16'hFFFF));
    send_request(byte_req(8'hF0, OVERRUN_MARK));
    send_request(tick_req(16'hFFFF));
    settle();
  endtask

  task automatic test_frame_extremes();
    // start byte gap is never checked, even an overrun mark
    send_frame(FILL_ONES, 8'hFF, OVERRUN_MARK, NO_BAD_BYTE, 16'h0, 0);
    settle();
  endtask

  task automatic test_gap_rules();
    write_register(CFG_GAP_LIMIT, 24'h0);
    send_frame(FILL_RANDOM, 8'($urandom), 16'($urandom), TAIL_BYTE, 16'h0001, 0);
    settle();
    // upper data bits fall outside the gap limit register
    write_register(CFG_GAP_LIMIT, 24'hFFFFFF);
    write_register(CFG_UNUSED_INDEX, 24'h000001);
    send_frame(FILL_RANDOM, 8'($urandom), 16'($urandom), 12, late_gap(), 0);
    settle();
    write_register(CFG_GAP_LIMIT, 24'd1024);
  endtask

  task automatic test_failsafe_timing();
    write_register(CFG_LOST_TIMEOUT, 24'd0);
    write_register(CFG_NOFRAME_TIMEOUT, 24'd0);
    // lost timer already runs from the frame with every flag set
    send_request(tick_req(16'd5));
    // ticks inside a frame must not disturb the gathering
    send_frame(FILL_RANDOM, 8'h04, 16'($urandom), NO_BAD_BYTE, 16'h0, 10);
    send_frame(FILL_ZEROS, 8'h00, 16'($urandom), NO_BAD_BYTE, 16'h0, 0);
    settle();
  endtask

  task automatic test_backpressure();
    write_register(CFG_LOST_TIMEOUT, 24'd150000);
    write_register(CFG_NOFRAME_TIMEOUT, 24'd200000);
    write_register(CFG_GAP_LIMIT, 24'($urandom_range(3000, 200)));
    steady = 1'b1;
    -> hold_start;
    send_frame(FILL_RANDOM, 8'($urandom), 16'($urandom), NO_BAD_BYTE, 16'h0, 0);
    repeat (5) send_request(tick_req(16'($urandom)));
    settle();
    steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_GAP_LIMIT;
    cfg_data_i = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_hunting();
    test_frame_extremes();
    test_gap_rules();
    test_failsafe_timing();
    test_backpressure();

    $display("covered %0d good frames, %0d rejected frames, %0d status reports",
             good_frames, rejected_frames, status_reports);
    $display("%0d requests sent, %0d results checked in %0d cycles, %0d mismatches",
             sent_count, checked_count, cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
design/sfr_pkg.sv
design/sfr_ram.sv
design/sfr_cmd_fifo.sv
design/sfr_front.sv
design/sfr_back.sv
design/sbus_frame_receiver_top.sv
bench/sbus_frame_receiver_top_tb.sv
